/* src/vrfc_pkg.sv */
// shared types, codes and constants of the rate floor checker
package vrfc_pkg;

	localparam int PAIR_W  = 2;
	localparam int STAMP_W = 32;
	localparam int VOL_W   = 48;
	localparam int RATE_W  = 48;
	localparam int HALF_W  = 24;
	localparam int CNT_W   = 5;
	localparam int WIN_W   = 5;
	localparam int AGE_W   = 32;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = VOL_W + HALF_W;
	localparam int ACC_W   = VOL_W + RATE_W + CNT_W;
	localparam int VSUM_W  = VOL_W + CNT_W;
	localparam int QUO_STEPS = RATE_W;
	localparam int STEP_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// operation codes from the front
	localparam logic [1:0] OP_RECORD   = 2'd0;
	localparam logic [1:0] OP_ZERO     = 2'd1;
	localparam logic [1:0] OP_VALIDATE = 2'd2;

	// verdict codes
	localparam logic [1:0] VERDICT_OK     = 2'd0;
	localparam logic [1:0] VERDICT_BELOW  = 2'd1;
	localparam logic [1:0] VERDICT_ABOVE  = 2'd2;
	localparam logic [1:0] VERDICT_NODATA = 2'd3;

	// reference kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_AVG  = 2'd1;
	localparam logic [1:0] KIND_SEED = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [PAIR_W-1:0]  pair;
		logic [STAMP_W-1:0] stamp;
		logic [VOL_W-1:0]   volume;
		logic [RATE_W-1:0]  rate;
	} item_t;

	typedef struct packed {
		logic [WIN_W-1:0]  window;
		logic [AGE_W-1:0]  max_age;
		logic [FRAC_W-1:0] floor_frac;
	} cfg_t;

	typedef struct packed {
		logic [PAIR_W-1:0]  pair;
		logic [STAMP_W-1:0] stamp;
		logic [VOL_W-1:0]   volume;
		logic [RATE_W-1:0]  rate;
	} hist_t;

	// per-pair seed rate in Q32.16
	function automatic logic [RATE_W-1:0] seed_rate(input logic [PAIR_W-1:0] p);
		logic [RATE_W-1:0] r;
		case (p)
			2'd0: r = {32'd17000, 16'd0};
			2'd1: r = {32'd214000, 16'd0};
			2'd2: r = {32'd46900, 16'd0};
			2'd3: r = {32'd34300, 16'd0};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* src/vwap_rate_floor_checker_unit.sv */
// top level: configuration registers, command front end and history back end
// a zero-rate validate answers without a walk; a record evicts the oldest entry on a full ring,
// writes, then evicts while over the cap; a validate walks entries, averages matches, divides
// and compares, or answers no-data; the worst case is set by the history memory walk
// one command is worked at a time; two more can wait in the front queue
// reset clears ring pointers, pair counts and registers to their defaults; results cannot be held off
module vwap_rate_floor_checker_unit #(
	parameter int HISTORY_DEPTH = 256,
	parameter int MIN_TRADES    = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cmd,
	input  logic [vrfc_pkg::PAIR_W-1:0]       pair,
	input  logic [vrfc_pkg::STAMP_W-1:0]      stamp,
	input  logic [vrfc_pkg::VOL_W-1:0]        volume,
	input  logic [vrfc_pkg::RATE_W-1:0]       rate,
	input  logic                              cfg_we,
	input  logic [vrfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vrfc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              done,
	output logic [1:0]                        verdict,
	output logic [vrfc_pkg::RATE_W-1:0]       reference_rate,
	output logic [1:0]                        reference_kind
);

	vrfc_pkg::cfg_t   cfg_q;
	vrfc_pkg::item_t  item;
	logic             item_valid;
	logic             pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window     <= vrfc_pkg::WIN_W'(20);
			cfg_q.max_age    <= vrfc_pkg::AGE_W'(604800);
			cfg_q.floor_frac <= vrfc_pkg::FRAC_W'(32768);
		end else if (cfg_we) begin
			case (cfg_index)
				vrfc_pkg::CFG_WINDOW:  cfg_q.window     <= cfg_data[vrfc_pkg::WIN_W-1:0];
				vrfc_pkg::CFG_MAX_AGE: cfg_q.max_age    <= cfg_data[vrfc_pkg::AGE_W-1:0];
				vrfc_pkg::CFG_FLOOR:   cfg_q.floor_frac <= cfg_data[vrfc_pkg::FRAC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	vrfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.pair       (pair),
		.stamp      (stamp),
		.volume     (volume),
		.rate       (rate),
		.busy       (busy),
		.pop        (pop),
		.item_valid (item_valid),
		.item       (item)
	);

	vrfc_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.MIN_TRADES    (MIN_TRADES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.item_valid     (item_valid),
		.item           (item),
		.pop            (pop),
		.done           (done),
		.verdict        (verdict),
		.reference_rate (reference_rate),
		.reference_kind (reference_kind)
	);

endmodule

/* src/vrfc_front.sv */
// front end: accepts commands, classifies them and queues them for the back end
module vrfc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          cmd,
	input  logic [vrfc_pkg::PAIR_W-1:0]   pair,
	input  logic [vrfc_pkg::STAMP_W-1:0]  stamp,
	input  logic [vrfc_pkg::VOL_W-1:0]    volume,
	input  logic [vrfc_pkg::RATE_W-1:0]   rate,
	output logic                          busy,
	input  logic                          pop,
	output logic                          item_valid,
	output vrfc_pkg::item_t               item
);

	vrfc_pkg::item_t queue_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      fill_q;
	logic            push;
	logic            take;
	vrfc_pkg::item_t incoming;

	assign busy       = (fill_q == 2'd2);
	assign push       = start && !busy;
	assign item_valid = (fill_q != 2'd0);
	assign take       = pop && item_valid;
	assign item       = queue_q[rd_ptr_q];

	// classify the incoming transaction
	always_comb begin
		incoming.pair   = pair;
		incoming.stamp  = stamp;
		incoming.volume = volume;
		incoming.rate   = rate;
		if (!cmd) begin
			incoming.op = vrfc_pkg::OP_RECORD;
		end else if (rate == '0) begin
			incoming.op = vrfc_pkg::OP_ZERO;
		end else begin
			incoming.op = vrfc_pkg::OP_VALIDATE;
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= incoming;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !take) begin
				fill_q <= fill_q + 2'd1;
			end else if (take && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

/* src/vrfc_div.sv */
// iterative restoring divider, one quotient bit per cycle
module vrfc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vrfc_pkg::ACC_W-1:0]   dividend,
	input  logic [vrfc_pkg::VSUM_W-1:0]  divisor,
	output logic                         done,
	output logic [vrfc_pkg::RATE_W-1:0]  quotient
);

	logic                          run_q;
	logic                          done_q;
	logic [vrfc_pkg::STEP_W-1:0]   step_q;
	logic [vrfc_pkg::VSUM_W-1:0]   rem_q;
	logic [vrfc_pkg::VSUM_W-1:0]   div_q;
	logic [vrfc_pkg::RATE_W-1:0]   low_q;
	logic [vrfc_pkg::VSUM_W:0]     trial;
	logic [vrfc_pkg::VSUM_W:0]     diff;
	logic                          ge;

	// one shift and trial subtract
	assign trial = {rem_q, low_q[vrfc_pkg::RATE_W-1]};
	assign ge    = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};

	assign done     = done_q;
	assign quotient = low_q;

	// datapath; the upper dividend part is below the divisor as the average fits 48 bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[vrfc_pkg::ACC_W-1:vrfc_pkg::RATE_W];
			low_q <= dividend[vrfc_pkg::RATE_W-1:0];
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[vrfc_pkg::VSUM_W-1:0] : trial[vrfc_pkg::VSUM_W-1:0];
			low_q <= {low_q[vrfc_pkg::RATE_W-2:0], ge};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == vrfc_pkg::STEP_W'(vrfc_pkg::QUO_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* src/vrfc_back.sv */
// back end: trade history ring, eviction, weighted average walk and verdict
module vrfc_back #(
	parameter int HISTORY_DEPTH = 256,
	parameter int MIN_TRADES    = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vrfc_pkg::cfg_t               cfg,
	input  logic                         item_valid,
	input  vrfc_pkg::item_t              item,
	output logic                         pop,
	output logic                         done,
	output logic [1:0]                   verdict,
	output logic [vrfc_pkg::RATE_W-1:0]  reference_rate,
	output logic [1:0]                   reference_kind
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int OCC_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CMP_W = (OCC_W > 9) ? OCC_W : 9;
	localparam int EXT_W = IDX_W + 2;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(HISTORY_DEPTH);
	localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(HISTORY_DEPTH);
	localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(HISTORY_DEPTH);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ZERO = 4'd1;
	localparam logic [3:0] S_RCHK = 4'd2;
	localparam logic [3:0] S_REV0 = 4'd3;
	localparam logic [3:0] S_RWR  = 4'd4;
	localparam logic [3:0] S_RCAP = 4'd5;
	localparam logic [3:0] S_REV1 = 4'd6;
	localparam logic [3:0] S_VRD  = 4'd7;
	localparam logic [3:0] S_VCHK = 4'd8;
	localparam logic [3:0] S_VM1  = 4'd9;
	localparam logic [3:0] S_VM2  = 4'd10;
	localparam logic [3:0] S_VFIN = 4'd11;
	localparam logic [3:0] S_VDIV = 4'd12;
	localparam logic [3:0] S_VCMP = 4'd13;

	logic [3:0]                     state_q;
	vrfc_pkg::item_t                cur_q;
	logic [IDX_W-1:0]               newest_q;
	logic [OCC_W-1:0]               occ_q;
	logic [OCC_W-1:0]               pcnt_q [4];
	logic [OCC_W-1:0]               k_q;
	logic [vrfc_pkg::CNT_W-1:0]     count_q;
	logic [vrfc_pkg::ACC_W-1:0]     acc_q;
	logic [vrfc_pkg::VSUM_W-1:0]    vsum_q;
	logic [vrfc_pkg::PROD_W-1:0]    prod_q;
	logic [vrfc_pkg::VOL_W-1:0]     vol_q;
	logic [vrfc_pkg::HALF_W-1:0]    rhi_q;
	logic [IDX_W-1:0]               slot_q;
	logic [vrfc_pkg::RATE_W-1:0]    ref_q;
	logic [1:0]                     kind_q;
	logic                           done_q;
	logic [1:0]                     verdict_q;
	logic [vrfc_pkg::RATE_W-1:0]    ref_out_q;
	logic [1:0]                     kind_out_q;

	vrfc_pkg::hist_t                mem [HISTORY_DEPTH];
	vrfc_pkg::hist_t                rd_q;
	vrfc_pkg::hist_t                wr_data;
	logic [IDX_W-1:0]               rd_addr;
	logic                           mem_we;

	logic [EXT_W-1:0]               base_ext;
	logic [EXT_W-1:0]               occ_ext;
	logic [EXT_W-1:0]               old_ext;
	logic [IDX_W-1:0]               oldest;
	logic [IDX_W-1:0]               newest_inc;
	logic [8:0]                     win10;
	logic [CMP_W-1:0]               win_cmp;
	logic [CMP_W-1:0]               cap;
	logic                           over_cap;
	logic [vrfc_pkg::STAMP_W:0]     age;
	logic                           stale;
	logic                           match;
	logic                           div_start;
	logic                           div_done;
	logic [vrfc_pkg::RATE_W-1:0]    div_quo;
	logic [63:0]                    floor_lhs;
	logic [63:0]                    floor_rhs;
	logic [vrfc_pkg::RATE_W+2:0]    rate5;

	// oldest slot of the ring
	assign base_ext = EXT_W'(newest_q) + EXT_W'(1);
	assign occ_ext  = EXT_W'(occ_q);
	assign old_ext  = (base_ext >= occ_ext) ? (base_ext - occ_ext)
	                                        : (base_ext + DEPTH_EXT - occ_ext);
	assign oldest   = old_ext[IDX_W-1:0];
	assign newest_inc = (newest_q == LAST_IDX) ? '0 : (newest_q + 1'b1);

	// ring cap is ten times the window, saturating at the depth
	assign win10    = ({4'd0, cfg.window} << 3) + ({4'd0, cfg.window} << 1);
	assign win_cmp  = CMP_W'(win10);
	assign cap      = (win_cmp > DEPTH_CMP) ? DEPTH_CMP : win_cmp;
	assign over_cap = (CMP_W'(occ_q) > cap);

	// age test; entries stamped in the future are never stale
	assign age   = {1'b0, cur_q.stamp} - {1'b0, rd_q.stamp};
	assign stale = (cfg.max_age != '0) && !age[vrfc_pkg::STAMP_W]
	               && (age[vrfc_pkg::STAMP_W-1:0] > cfg.max_age);
	assign match = (rd_q.pair == cur_q.pair) && !stale;

	// verdict compares
	assign floor_lhs = 64'(cur_q.rate) * 64'(cfg.floor_frac);
	assign floor_rhs = {ref_q, 16'd0};
	assign rate5     = {1'b0, cur_q.rate, 2'b00} + {3'b000, cur_q.rate};

	assign pop       = (state_q == S_IDLE) && item_valid;
	assign mem_we    = (state_q == S_RWR);
	assign rd_addr   = (state_q == S_VRD) ? slot_q : oldest;
	assign div_start = (state_q == S_VFIN) && (count_q >= vrfc_pkg::CNT_W'(MIN_TRADES))
	                   && (vsum_q != '0);

	always_comb begin
		wr_data.pair   = cur_q.pair;
		wr_data.stamp  = cur_q.stamp;
		wr_data.volume = cur_q.volume;
		wr_data.rate   = cur_q.rate;
	end

	// history memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[newest_inc] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	vrfc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (vsum_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// walk datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= item;
		end
		case (state_q)
			S_VCHK: begin
				prod_q <= rd_q.volume * rd_q.rate[vrfc_pkg::HALF_W-1:0];
				vol_q  <= rd_q.volume;
				rhi_q  <= rd_q.rate[vrfc_pkg::RATE_W-1:vrfc_pkg::HALF_W];
			end
			S_VM1: begin
				prod_q <= vol_q * rhi_q;
			end
			default: begin
			end
		endcase
	end

	// control and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			newest_q   <= '0;
			occ_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				pcnt_q[i] <= '0;
			end
			k_q        <= '0;
			count_q    <= '0;
			acc_q      <= '0;
			vsum_q     <= '0;
			slot_q     <= '0;
			ref_q      <= '0;
			kind_q     <= vrfc_pkg::KIND_NONE;
			done_q     <= 1'b0;
			verdict_q  <= vrfc_pkg::VERDICT_OK;
			ref_out_q  <= '0;
			kind_out_q <= vrfc_pkg::KIND_NONE;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						k_q     <= '0;
						count_q <= '0;
						acc_q   <= '0;
						vsum_q  <= '0;
						slot_q  <= newest_q;
						case (item.op)
							vrfc_pkg::OP_RECORD:   state_q <= S_RCHK;
							vrfc_pkg::OP_VALIDATE: state_q <= S_VRD;
							default:               state_q <= S_ZERO;
						endcase
					end
				end
				S_ZERO: begin
					done_q     <= 1'b1;
					verdict_q  <= vrfc_pkg::VERDICT_BELOW;
					ref_out_q  <= '0;
					kind_out_q <= vrfc_pkg::KIND_NONE;
					state_q    <= S_IDLE;
				end
				S_RCHK: begin
					state_q <= (occ_q == FULL_OCC) ? S_REV0 : S_RWR;
				end
				S_REV0, S_REV1: begin
					for (int i = 0; i < 4; i++) begin
						if (rd_q.pair == 2'(i)) begin
							pcnt_q[i] <= pcnt_q[i] - 1'b1;
						end
					end
					occ_q   <= occ_q - 1'b1;
					state_q <= (state_q == S_REV0) ? S_RWR : S_RCAP;
				end
				S_RWR: begin
					for (int i = 0; i < 4; i++) begin
						if (cur_q.pair == 2'(i)) begin
							pcnt_q[i] <= pcnt_q[i] + 1'b1;
						end
					end
					newest_q <= newest_inc;
					occ_q    <= occ_q + 1'b1;
					state_q  <= S_RCAP;
				end
				S_RCAP: begin
					if (over_cap) begin
						state_q <= S_REV1;
					end else begin
						done_q     <= 1'b1;
						verdict_q  <= vrfc_pkg::VERDICT_OK;
						ref_out_q  <= '0;
						kind_out_q <= vrfc_pkg::KIND_NONE;
						state_q    <= S_IDLE;
					end
				end
				S_VRD: begin
					if ((k_q < occ_q) && (count_q < cfg.window)) begin
						slot_q  <= (slot_q == '0) ? LAST_IDX : (slot_q - 1'b1);
						k_q     <= k_q + 1'b1;
						state_q <= S_VCHK;
					end else begin
						state_q <= S_VFIN;
					end
				end
				S_VCHK: begin
					state_q <= match ? S_VM1 : S_VRD;
				end
				S_VM1: begin
					acc_q   <= acc_q + vrfc_pkg::ACC_W'(prod_q);
					state_q <= S_VM2;
				end
				S_VM2: begin
					acc_q   <= acc_q + vrfc_pkg::ACC_W'({prod_q, {vrfc_pkg::HALF_W{1'b0}}});
					vsum_q  <= vsum_q + vrfc_pkg::VSUM_W'(vol_q);
					count_q <= count_q + 1'b1;
					state_q <= S_VRD;
				end
				S_VFIN: begin
					if (div_start) begin
						state_q <= S_VDIV;
					end else if (pcnt_q[cur_q.pair] != '0) begin
						ref_q   <= vrfc_pkg::seed_rate(cur_q.pair);
						kind_q  <= vrfc_pkg::KIND_SEED;
						state_q <= S_VCMP;
					end else begin
						done_q     <= 1'b1;
						verdict_q  <= vrfc_pkg::VERDICT_NODATA;
						ref_out_q  <= '0;
						kind_out_q <= vrfc_pkg::KIND_NONE;
						state_q    <= S_IDLE;
					end
				end
				S_VDIV: begin
					if (div_done) begin
						ref_q   <= div_quo;
						kind_q  <= vrfc_pkg::KIND_AVG;
						state_q <= S_VCMP;
					end
				end
				S_VCMP: begin
					done_q     <= 1'b1;
					ref_out_q  <= ref_q;
					kind_out_q <= kind_q;
					if (floor_lhs > floor_rhs) begin
						verdict_q <= vrfc_pkg::VERDICT_BELOW;
					end else if (rate5 < {3'b000, ref_q}) begin
						verdict_q <= vrfc_pkg::VERDICT_ABOVE;
					end else begin
						verdict_q <= vrfc_pkg::VERDICT_OK;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign verdict        = verdict_q;
	assign reference_rate = ref_out_q;
	assign reference_kind = kind_out_q;

	// ring never holds more than its depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_OCC)
		else $error("occupancy above depth");

	// result strobes never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("back-to-back result strobes");

	// an average reference never comes with a no-data verdict
	a_avg_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && kind_out_q == vrfc_pkg::KIND_AVG) |-> verdict_q != vrfc_pkg::VERDICT_NODATA)
		else $error("average reference with no-data verdict");

	// division only starts with enough trades
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VDIV) |-> (count_q >= vrfc_pkg::CNT_W'(MIN_TRADES)))
		else $error("divider running with too few trades");

endmodule

/* dv/tb_vwap_rate_floor_checker_unit.sv */
// testbench of the rate floor checker: directed table, then random phases checked by a predictor
module tb_vwap_rate_floor_checker_unit;

	localparam bit CMD_RECORD   = 1'b0;
	localparam bit CMD_VALIDATE = 1'b1;
	localparam int RING_DEPTH   = 256;
	localparam int AVG_MIN      = 5;
	localparam int DRAIN_CYCLES = 700;
	localparam int NUM_PHASES   = 9;

	typedef struct {
		bit                           cmd;
		bit [vrfc_pkg::PAIR_W-1:0]    pair;
		bit [vrfc_pkg::STAMP_W-1:0]   stamp;
		bit [vrfc_pkg::VOL_W-1:0]     volume;
		bit [vrfc_pkg::RATE_W-1:0]    rate;
		bit                           typed;
		bit [1:0]                     verdict;
		bit [vrfc_pkg::RATE_W-1:0]    ref_rate;
		bit [1:0]                     kind;
	} trade_cmd_t;

	typedef struct {
		bit [1:0]                  verdict;
		bit [vrfc_pkg::RATE_W-1:0] ref_rate;
		bit [1:0]                  kind;
	} verdict_t;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic                            cmd;
	logic [vrfc_pkg::PAIR_W-1:0]     pair;
	logic [vrfc_pkg::STAMP_W-1:0]    stamp;
	logic [vrfc_pkg::VOL_W-1:0]      volume;
	logic [vrfc_pkg::RATE_W-1:0]     rate;
	logic                            cfg_we;
	logic [vrfc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [vrfc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            done;
	logic [1:0]                      verdict;
	logic [vrfc_pkg::RATE_W-1:0]     reference_rate;
	logic [1:0]                      reference_kind;

	vwap_rate_floor_checker_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .pair(pair),
		.stamp(stamp), .volume(volume), .rate(rate), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .verdict(verdict),
		.reference_rate(reference_rate), .reference_kind(reference_kind)
	);

	// predictor state: trade ring, pair counts and register copies
	bit [vrfc_pkg::PAIR_W-1:0]  ring_pair [RING_DEPTH];
	bit [vrfc_pkg::STAMP_W-1:0] ring_time [RING_DEPTH];
	bit [vrfc_pkg::VOL_W-1:0]   ring_vol  [RING_DEPTH];
	bit [vrfc_pkg::RATE_W-1:0]  ring_rate [RING_DEPTH];
	int                         ring_newest;
	int                         ring_occ;
	int                         trades_per_pair [4];
	int                         win_trades;
	bit [vrfc_pkg::AGE_W-1:0]   age_limit;
	bit [vrfc_pkg::FRAC_W-1:0]  floor_frac;
	bit [vrfc_pkg::RATE_W-1:0]  pair_seed [4];

	verdict_t   pending_verdicts [$];
	int         error_count;
	bit [31:0]  trade_clock;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#(8 * 4000000);
		$display("vwap_rate_floor_checker_unit test failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void drop_oldest_trade();
		int s;
		s = (ring_newest + RING_DEPTH + 1 - ring_occ) % RING_DEPTH;
		trades_per_pair[ring_pair[s]]--;
		ring_occ--;
	endfunction

	// predicted verdict for one transaction, updates the ring
	function automatic verdict_t predict_verdict(input trade_cmd_t t);
		verdict_t   r;
		int         cap;
		int         count;
		int         s;
		longint     age;
		bit [127:0] wsum;
		bit [127:0] vsum;
		bit [127:0] quo;
		r = '{vrfc_pkg::VERDICT_OK, '0, vrfc_pkg::KIND_NONE};
		if (t.cmd == CMD_RECORD) begin
			cap = win_trades * 10;
			if (cap > RING_DEPTH) cap = RING_DEPTH;
			if (ring_occ >= RING_DEPTH) drop_oldest_trade();
			ring_newest = (ring_newest + 1) % RING_DEPTH;
			ring_pair[ring_newest] = t.pair;
			ring_time[ring_newest] = t.stamp;
			ring_vol[ring_newest]  = t.volume;
			ring_rate[ring_newest] = t.rate;
			ring_occ++;
			trades_per_pair[t.pair]++;
			while (ring_occ > cap) drop_oldest_trade();
		end else if (t.rate == 0) begin
			r.verdict = vrfc_pkg::VERDICT_BELOW;
		end else begin
			wsum = '0;
			vsum = '0;
			count = 0;
			for (int k = 0; k < ring_occ && count < win_trades; k++) begin
				s = (ring_newest + RING_DEPTH - k) % RING_DEPTH;
				if (ring_pair[s] != t.pair) continue;
				age = longint'(t.stamp) - longint'(ring_time[s]);
				if (age_limit != 0 && age > longint'(age_limit)) continue;
				wsum += 128'(ring_vol[s]) * 128'(ring_rate[s]);
				vsum += 128'(ring_vol[s]);
				count++;
			end
			if (count >= AVG_MIN && vsum != 0) begin
				quo = wsum / vsum;
				r.ref_rate = quo[vrfc_pkg::RATE_W-1:0];
				r.kind = vrfc_pkg::KIND_AVG;
			end else if (trades_per_pair[t.pair] > 0) begin
				r.ref_rate = pair_seed[t.pair];
				r.kind = vrfc_pkg::KIND_SEED;
			end else begin
				r.verdict = vrfc_pkg::VERDICT_NODATA;
			end
			if (r.kind != vrfc_pkg::KIND_NONE) begin
				if (64'(t.rate) * 64'(floor_frac) > {r.ref_rate, 16'd0})
					r.verdict = vrfc_pkg::VERDICT_BELOW;
				else if (64'(t.rate) * 64'd5 < 64'(r.ref_rate))
					r.verdict = vrfc_pkg::VERDICT_ABOVE;
				else
					r.verdict = vrfc_pkg::VERDICT_OK;
			end
		end
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result with no transaction pending");
			end else begin
				e = pending_verdicts[0];
				pending_verdicts.delete(0);
				if (verdict !== e.verdict)
					report_mismatch($sformatf("verdict %0d, expected %0d", verdict, e.verdict));
				if (reference_rate !== e.ref_rate)
					report_mismatch($sformatf("reference_rate %0h, expected %0h",
						reference_rate, e.ref_rate));
				if (reference_kind !== e.kind)
					report_mismatch($sformatf("reference_kind %0d, expected %0d",
						reference_kind, e.kind));
			end
		end
	end

	// drive one transaction and hold it until accepted
	task automatic send_trade_cmd(input trade_cmd_t t);
		verdict_t r;
		start  <= 1'b1;
		cmd    <= t.cmd;
		pair   <= t.pair;
		stamp  <= t.stamp;
		volume <= t.volume;
		rate   <= t.rate;
		do @(posedge clk); while (busy);
		r = predict_verdict(t);
		if (t.typed) r = '{t.verdict, t.ref_rate, t.kind};
		pending_verdicts.insert(pending_verdicts.size(), r);
	endtask

	task automatic write_reg(input logic [vrfc_pkg::CFG_IDX_W-1:0] idx,
			input logic [vrfc_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			vrfc_pkg::CFG_WINDOW:  win_trades = val[vrfc_pkg::WIN_W-1:0];
			vrfc_pkg::CFG_MAX_AGE: age_limit  = val[vrfc_pkg::AGE_W-1:0];
			vrfc_pkg::CFG_FLOOR:   floor_frac = val[vrfc_pkg::FRAC_W-1:0];
			default: ;
		endcase
	endtask

	// wait for every pending result and for the block to settle
	task automatic drain();
		start <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic bit [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic trade_cmd_t row(input bit c, input bit [1:0] p, input bit [31:0] st,
			input bit [47:0] v, input bit [47:0] rt);
		trade_cmd_t t;
		t = '{c, p, st, v, rt, 1'b0, vrfc_pkg::VERDICT_OK, '0, vrfc_pkg::KIND_NONE};
		return t;
	endfunction

	function automatic trade_cmd_t typed_row(input trade_cmd_t t, input bit [1:0] vd,
			input bit [47:0] rr, input bit [1:0] k);
		t.typed = 1'b1;
		t.verdict = vd;
		t.ref_rate = rr;
		t.kind = k;
		return t;
	endfunction

	// random transaction, mostly records near the running trade clock
	function automatic trade_cmd_t random_trade_cmd(input int record_pct);
		trade_cmd_t  t;
		bit [63:0]   base;
		t = row(CMD_VALIDATE, 2'($urandom_range(0, 3)), 0, 0, 0);
		base = 64'(pair_seed[t.pair]);
		if ($urandom_range(0, 99) < record_pct) begin
			t.cmd = CMD_RECORD;
			trade_clock += $urandom_range(0, 20);
			t.stamp = trade_clock;
			case ($urandom_range(0, 9))
				0: t.volume = rand48();
				1: t.volume = '0;
				default: t.volume = $urandom_range(1, 100000);
			endcase
			if ($urandom_range(0, 9) == 0) t.rate = rand48();
			else t.rate = 48'(base / 2 + {$urandom, $urandom} % base);
			t.volume = t.volume ^ (($urandom_range(0, 19) == 0) ? rand48() : 48'd0);
		end else begin
			case ($urandom_range(0, 9))
				0: t.stamp = $urandom;
				1: t.stamp = trade_clock - $urandom_range(0, 100);
				default: t.stamp = trade_clock + $urandom_range(0, 50);
			endcase
			case ($urandom_range(0, 19))
				0: t.rate = '0;
				1, 2: t.rate = rand48();
				3, 4: t.rate = $urandom_range(1, 1000);
				default: t.rate = 48'(base * $urandom_range(10, 250) / 100);
			endcase
			t.volume = rand48();
		end
		return t;
	endfunction

	initial begin
		trade_cmd_t dir_rows [$];
		trade_cmd_t t;
		int win_set [NUM_PHASES];
		bit [31:0] age_set [NUM_PHASES];
		bit [15:0] frac_set [NUM_PHASES];
		int n_items;
		int rec_pct;
		bit last_phase;

		// predictor reset state
		pair_seed = '{48'd17000 << 16, 48'd214000 << 16, 48'd46900 << 16, 48'd34300 << 16};
		ring_newest = 0;
		ring_occ = 0;
		trades_per_pair = '{0, 0, 0, 0};
		win_trades = 20;
		age_limit = 604800;
		floor_frac = 32768;
		error_count = 0;
		trade_clock = $urandom;

		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = 1'b0;
		pair      = '0;
		stamp     = '0;
		volume    = '0;
		rate      = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset configuration
		dir_rows.insert(dir_rows.size(), typed_row(row(CMD_VALIDATE, 0, 1000, 0, 0),
			vrfc_pkg::VERDICT_BELOW, 0, vrfc_pkg::KIND_NONE));
		dir_rows.insert(dir_rows.size(), typed_row(row(CMD_VALIDATE, 1, 1000, 0, 1),
			vrfc_pkg::VERDICT_NODATA, 0, vrfc_pkg::KIND_NONE));
		dir_rows.insert(dir_rows.size(), typed_row(row(CMD_RECORD, 0, 0, '1, '1),
			vrfc_pkg::VERDICT_OK, 0, vrfc_pkg::KIND_NONE));
		dir_rows.insert(dir_rows.size(), typed_row(row(CMD_RECORD, 0, '1, 0, 0),
			vrfc_pkg::VERDICT_OK, 0, vrfc_pkg::KIND_NONE));
		for (int i = 0; i < 5; i++)
			dir_rows.insert(dir_rows.size(), typed_row(row(CMD_RECORD, 2, 1000, 100 * (i + 1),
				(48'd46000 + 48'(i) * 500) << 16), vrfc_pkg::VERDICT_OK, 0,
				vrfc_pkg::KIND_NONE));
		dir_rows.insert(dir_rows.size(), row(CMD_VALIDATE, 2, 1000, 0, 48'd47000 << 16));
		dir_rows.insert(dir_rows.size(), row(CMD_VALIDATE, 2, 1000, 0, '1));
		dir_rows.insert(dir_rows.size(), row(CMD_VALIDATE, 2, 1000, 0, 1));
		dir_rows.insert(dir_rows.size(), row(CMD_VALIDATE, 0, 1000, 0, 48'd17000 << 16));
		dir_rows.insert(dir_rows.size(), typed_row(row(CMD_VALIDATE, 3, 1000, 0, 5),
			vrfc_pkg::VERDICT_NODATA, 0, vrfc_pkg::KIND_NONE));
		dir_rows.insert(dir_rows.size(), row(CMD_VALIDATE, 2, 2000000, 0, 48'd46900 << 16));
		for (int i = 0; i < 5; i++)
			dir_rows.insert(dir_rows.size(), typed_row(row(CMD_RECORD, 1, 500, 0,
				48'd300000 << 16), vrfc_pkg::VERDICT_OK, 0, vrfc_pkg::KIND_NONE));
		dir_rows.insert(dir_rows.size(), row(CMD_VALIDATE, 1, 600, 0, 48'd214000 << 16));
		dir_rows.insert(dir_rows.size(), row(CMD_VALIDATE, 1, 600, 0, 48'd10000 << 16));
		foreach (dir_rows[i]) send_trade_cmd(dir_rows[i]);
		drain();

		// random phases, each under its own register setting
		win_set  = '{31, 31, 25, 1, 0, 5, 20, 31, $urandom_range(1, 25)};
		age_set  = '{0, 604800, 32'hFFFF_FFFF, 1, 300, 0, $urandom_range(20, 400), 60, $urandom};
		frac_set = '{32768, 65535, 1, 0, 40000, 16'hFFFF, 16'($urandom), 20000, 32768};
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_reg(vrfc_pkg::CFG_WINDOW, win_set[ph]);
			write_reg(vrfc_pkg::CFG_MAX_AGE, age_set[ph]);
			write_reg(vrfc_pkg::CFG_FLOOR, frac_set[ph]);
			cfg_we <= 1'b0;
			n_items = (ph == 0) ? 300 : 90;
			rec_pct = (ph == 0) ? 90 : 55;
			last_phase = (ph == NUM_PHASES - 1);
			for (int i = 0; i < n_items; i++) begin
				t = random_trade_cmd(rec_pct);
				send_trade_cmd(t);
				// idle bursts from the sender, none in the closing phase
				if (!last_phase && $urandom_range(0, 3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
			end
			drain();
		end

		if (error_count == 0)
			$display("vwap_rate_floor_checker_unit test passed");
		else
			$display("vwap_rate_floor_checker_unit test failed");
		$finish;
	end

endmodule

/* files.f */
src/vrfc_pkg.sv
src/vrfc_front.sv
src/vrfc_div.sv
src/vrfc_back.sv
src/vwap_rate_floor_checker_unit.sv
dv/tb_vwap_rate_floor_checker_unit.sv
